// ===== rtl/sensor_limit_safety_monitor_defines.svh =====
// Assertion macros shared by the checker files of the safety monitor.
// No dependencies; include by bare file name.
`ifndef SENSOR_LIMIT_SAFETY_MONITOR_DEFINES_SVH
`define SENSOR_LIMIT_SAFETY_MONITOR_DEFINES_SVH

// Property checked while reset is low.
`define SLSM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Property checked at every edge, reset included.
`define SLSM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/slsm_pkg.sv =====
// Shared types, constants and field layout for the sensor limit safety monitor.
// No dependencies.
`timescale 1ns / 1ps

package slsm_pkg;

  localparam int SENSORS  = 16;
  localparam int VALUE_W  = 32;
  localparam int MASK_W   = 16;
  // token holds a count of sensors still to check, 0..SENSORS
  localparam int CNT_W    = $clog2(SENSORS + 1);

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_HEARTBEAT = 2'd1,
    CMD_VALUE     = 2'd2,
    CMD_LIMIT     = 2'd3
  } cmd_t;

  // register indexes on the write port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_BOARD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEARTBEAT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_SEC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_SEC    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT  = 3'd6;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic        RST_POWER_BOARD   = 1'b1;
  localparam logic [15:0] RST_OVERLOAD_MASK = 16'd0;
  localparam logic [7:0]  RST_TICKS_PER_SEC = 8'd20;
  localparam logic [7:0]  RST_MIN_HEARTBEAT = 8'd4;
  localparam logic [7:0]  RST_STARTUP_SEC   = 8'd10;
  localparam logic [7:0]  RST_REPORT_SEC    = 8'd5;
  localparam logic [4:0]  RST_SENSOR_COUNT  = 5'd16;

  // input request layout
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_VAL_LSB   = 4;
  localparam int IN_LOW_LSB   = IN_VAL_LSB + VALUE_W;
  localparam int IN_HIGH_LSB  = IN_LOW_LSB + VALUE_W;
  localparam int IN_OV_LSB    = IN_HIGH_LSB + VALUE_W;
  localparam int IN_BITS      = IN_OV_LSB + 16;
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;

  // result layout
  localparam int OUT_SAFE_BIT  = 0;
  localparam int OUT_SHUT_BIT  = 1;
  localparam int OUT_CLR_BIT   = 2;
  localparam int OUT_REP_BIT   = 3;
  localparam int OUT_ABOVE_LSB = 4;
  localparam int OUT_BELOW_LSB = OUT_ABOVE_LSB + MASK_W;
  localparam int OUT_SCHED_BIT = OUT_BELOW_LSB + MASK_W;
  localparam int OUT_PERS_LSB  = OUT_SCHED_BIT + 1;
  localparam int OUT_BITS      = OUT_PERS_LSB + 16;
  localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;

  // write broadcast to the sensor cells
  typedef struct packed {
    logic               ld_value;
    logic               ld_limits;
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] low;
    logic [VALUE_W-1:0] high;
  } cell_wr_t;

endpackage

// ===== rtl/slsm_cell.sv =====
// One sensor cell: reading, limits and sticky trip flags of one sensor.
// Depends on slsm_pkg. Passes the scan token to the next cell each cycle.
`timescale 1ns / 1ps

module slsm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  slsm_pkg::cell_wr_t         wr,
  input  logic                       sel,
  input  logic [slsm_pkg::CNT_W-1:0] tok_in,
  output logic [slsm_pkg::CNT_W-1:0] tok_out,
  output logic                       above,
  output logic                       below
);
  import slsm_pkg::*;

  logic signed [VALUE_W-1:0] reading;
  logic signed [VALUE_W-1:0] lower;
  logic signed [VALUE_W-1:0] upper;
  logic                      active;

  assign active = (tok_in != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      reading <= '0;
      lower   <= '0;
      upper   <= '0;
      tok_out <= '0;
      above   <= 1'b0;
      below   <= 1'b0;
    end else begin
      if (sel && wr.ld_limits) begin
        lower   <= wr.low;
        upper   <= wr.high;
        reading <= wr.value;
      end else if (sel && wr.ld_value) begin
        reading <= wr.value;
      end
      tok_out <= active ? tok_in - CNT_W'(1) : '0;
      if (active && (reading > upper)) above <= 1'b1;
      if (active && (reading < lower)) below <= 1'b1;
    end
  end

endmodule

// ===== rtl/sensor_limit_safety_monitor.sv =====
// Top level of the sensor limit safety monitor: stream ports, registers,
// timing counters and the row of slsm_cell sensor cells. Depends on slsm_pkg.
`timescale 1ns / 1ps

// Commands arrive on s_axis with cmd in tuser; every request yields one result
// on m_axis. Heartbeats, value and limit writes and most ticks are answered in
// the next cycle. A tick that closes a second after the startup delay starts a
// limit scan: a token walks the row of SENSORS cells one cell per cycle, and the
// result follows the scan and done states. A new request is taken once the
// previous result has left or is taken in the same cycle. Registers are to be
// written on the cfg_wr port only while idle; the block does not enforce it.
module sensor_limit_safety_monitor (
  input  logic                           clk,
  input  logic                           rst,
  // tdata: sensor_index, sensor_value, limit_low, limit_high, overload_bits
  input  logic [slsm_pkg::IN_W-1:0]      s_axis_tdata,
  // tuser: cmd
  input  logic [1:0]                     s_axis_tuser,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: safe_mode, shut_down_now, overload_clear, report_due,
  //        above_tripped, below_tripped, scheduler_failed, persistent_overload
  output logic [slsm_pkg::OUT_W-1:0]     m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_wr_en,
  input  logic [slsm_pkg::CFG_IDX_W-1:0] cfg_wr_index,
  input  logic [slsm_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import slsm_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t state;

  // registers
  logic        power_board_present;
  logic [15:0] overload_mask;
  logic [7:0]  ticks_per_second;
  logic [7:0]  min_heartbeats;
  logic [7:0]  startup_seconds;
  logic [7:0]  report_seconds;
  logic [4:0]  sensor_count;

  // monitor state
  logic [7:0]  tick_phase;
  logic [15:0] seconds_elapsed;
  logic [7:0]  report_phase;
  logic [7:0]  heartbeat_count;
  logic [15:0] previous_overload;
  logic [15:0] overload_found;
  logic        in_safe;
  logic        watchdog_failed;

  // held across a scan
  logic             rep_hit;
  logic             clr_hold;
  logic [CNT_W-1:0] scan_cnt;
  logic [CNT_W-1:0] tok_head;

  // result register
  logic        out_safe, out_shut, out_clr, out_rep, out_sched;
  logic [15:0] out_pers;
  logic [MASK_W-1:0] out_above, out_below;

  // request fields
  cmd_t               cmd;
  logic [3:0]         sensor_index;
  logic [VALUE_W-1:0] sensor_value, limit_low, limit_high;
  logic [15:0]        overload_bits;

  assign cmd           = cmd_t'(s_axis_tuser);
  assign sensor_index  = s_axis_tdata[IN_IDX_LSB +: 4];
  assign sensor_value  = s_axis_tdata[IN_VAL_LSB +: VALUE_W];
  assign limit_low     = s_axis_tdata[IN_LOW_LSB +: VALUE_W];
  assign limit_high    = s_axis_tdata[IN_HIGH_LSB +: VALUE_W];
  assign overload_bits = s_axis_tdata[IN_OV_LSB +: 16];

  logic accept;
  assign s_axis_tready = (state == ST_IDLE) && (!m_axis_tvalid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // cell row
  cell_wr_t             cell_wr;
  logic [SENSORS-1:0]   cell_sel;
  logic [CNT_W-1:0]     tok [SENSORS+1];
  logic [SENSORS-1:0]   above_v, below_v;
  logic [VALUE_W-1:0]   mid_x;

  // floor of the average without overflow
  assign mid_x = limit_low ^ limit_high;

  always_comb begin
    cell_wr.ld_value  = accept && (cmd == CMD_VALUE);
    cell_wr.ld_limits = accept && (cmd == CMD_LIMIT);
    cell_wr.low       = limit_low;
    cell_wr.high      = limit_high;
    cell_wr.value     = (cmd == CMD_LIMIT) ?
                        (limit_low & limit_high) + {mid_x[VALUE_W-1], mid_x[VALUE_W-1:1]} :
                        sensor_value;
  end

  assign tok[0] = tok_head;

  for (genvar i = 0; i < SENSORS; i++) begin : g_cell
    assign cell_sel[i] = (32'(sensor_index) == i);
    slsm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (cell_wr),
      .sel     (cell_sel[i]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .above   (above_v[i]),
      .below   (below_v[i])
    );
  end

  logic [MASK_W-1:0] above_shown, below_shown;
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      above_shown[i] = (i < SENSORS) ? above_v[i % SENSORS] : 1'b0;
      below_shown[i] = (i < SENSORS) ? below_v[i % SENSORS] : 1'b0;
    end
  end

  logic [CNT_W-1:0] scan_n;
  assign scan_n = (32'(sensor_count) >= SENSORS) ? CNT_W'(SENSORS) : CNT_W'(sensor_count);

  // tick arithmetic
  logic [8:0]  tps_eff, rps_eff, tick_inc, rep_inc;
  logic        sec_end, rep_end, checks;
  logic [7:0]  tick_phase_next, report_phase_next;
  logic [15:0] seconds_next;
  logic        ov_run, clr_now, safe_tick, wd_next;
  logic [15:0] found_next;

  always_comb begin
    tps_eff  = (ticks_per_second == 8'd0) ? 9'd1 : {1'b0, ticks_per_second};
    rps_eff  = (report_seconds == 8'd0) ? 9'd1 : {1'b0, report_seconds};
    tick_inc = {1'b0, tick_phase} + 9'd1;
    sec_end  = (tick_inc >= tps_eff);
    tick_phase_next = sec_end ? 8'd0 : tick_inc[7:0];
    seconds_next = (sec_end && (seconds_elapsed != 16'hFFFF)) ?
                   seconds_elapsed + 16'd1 : seconds_elapsed;
    checks   = sec_end && (seconds_next > {8'd0, startup_seconds});
    rep_inc  = {1'b0, report_phase} + 9'd1;
    rep_end  = sec_end && (rep_inc >= rps_eff);
    report_phase_next = !sec_end ? report_phase : (rep_end ? 8'd0 : rep_inc[7:0]);

    ov_run     = power_board_present && !in_safe;
    clr_now    = ov_run && (overload_bits != 16'd0);
    found_next = ov_run ? (overload_bits & previous_overload & overload_mask)
                        : overload_found;
    wd_next    = watchdog_failed || (checks && (heartbeat_count < min_heartbeats));
    safe_tick  = in_safe || (found_next != 16'd0) || wd_next;
  end

  logic safe_fin;
  assign safe_fin = in_safe || (|above_v) || (|below_v);

  // a result is loaded on any request but a scan start, and when a scan ends
  logic out_load;
  assign out_load = ((state == ST_IDLE) && accept && !((cmd == CMD_TICK) && checks)) ||
                    ((state == ST_DONE) && (!m_axis_tvalid || m_axis_tready));

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_board_present <= RST_POWER_BOARD;
      overload_mask       <= RST_OVERLOAD_MASK;
      ticks_per_second    <= RST_TICKS_PER_SEC;
      min_heartbeats      <= RST_MIN_HEARTBEAT;
      startup_seconds     <= RST_STARTUP_SEC;
      report_seconds      <= RST_REPORT_SEC;
      sensor_count        <= RST_SENSOR_COUNT;
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        CFG_POWER_BOARD:   power_board_present <= cfg_wr_data[0];
        CFG_OVERLOAD_MASK: overload_mask       <= cfg_wr_data[15:0];
        CFG_TICKS_PER_SEC: ticks_per_second    <= cfg_wr_data[7:0];
        CFG_MIN_HEARTBEAT: min_heartbeats      <= cfg_wr_data[7:0];
        CFG_STARTUP_SEC:   startup_seconds     <= cfg_wr_data[7:0];
        CFG_REPORT_SEC:    report_seconds      <= cfg_wr_data[7:0];
        CFG_SENSOR_COUNT:  sensor_count        <= cfg_wr_data[4:0];
        default: ;
      endcase
    end
  end

  // control and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      tick_phase        <= '0;
      seconds_elapsed   <= '0;
      report_phase      <= '0;
      heartbeat_count   <= '0;
      previous_overload <= '0;
      overload_found    <= '0;
      in_safe           <= 1'b0;
      watchdog_failed   <= 1'b0;
      rep_hit           <= 1'b0;
      clr_hold          <= 1'b0;
      scan_cnt          <= '0;
      tok_head          <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_TICK: begin
                tick_phase      <= tick_phase_next;
                seconds_elapsed <= seconds_next;
                report_phase    <= report_phase_next;
                overload_found  <= found_next;
                if (ov_run) previous_overload <= overload_bits;
                watchdog_failed <= wd_next;
                in_safe         <= safe_tick;
                if (checks) begin
                  heartbeat_count <= '0;
                  rep_hit  <= rep_end;
                  clr_hold <= clr_now;
                  tok_head <= scan_n;
                  scan_cnt <= '0;
                  state    <= ST_SCAN;
                end else begin
                  out_safe      <= safe_tick;
                  out_shut      <= safe_tick;
                  out_clr       <= clr_now;
                  out_rep       <= rep_end && safe_tick;
                  out_sched     <= wd_next;
                  out_pers      <= found_next;
                  out_above     <= above_shown;
                  out_below     <= below_shown;
                end
              end
              CMD_HEARTBEAT: begin
                if (heartbeat_count != 8'hFF) heartbeat_count <= heartbeat_count + 8'd1;
              end
              default: ;
            endcase
            if (cmd != CMD_TICK) begin
              out_safe  <= in_safe;
              out_shut  <= 1'b0;
              out_clr   <= 1'b0;
              out_rep   <= 1'b0;
              out_sched <= watchdog_failed;
              out_pers  <= overload_found;
              out_above <= above_shown;
              out_below <= below_shown;
            end
          end
        end
        ST_SCAN: begin
          tok_head <= '0;
          if (scan_cnt == CNT_W'(SENSORS - 1)) state <= ST_DONE;
          else scan_cnt <= scan_cnt + CNT_W'(1);
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            in_safe       <= safe_fin;
            out_safe      <= safe_fin;
            out_shut      <= safe_fin;
            out_clr       <= clr_hold;
            out_rep       <= rep_hit && safe_fin;
            out_sched     <= watchdog_failed;
            out_pers      <= overload_found;
            out_above     <= above_shown;
            out_below     <= below_shown;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[OUT_SAFE_BIT]             = out_safe;
    m_axis_tdata[OUT_SHUT_BIT]             = out_shut;
    m_axis_tdata[OUT_CLR_BIT]              = out_clr;
    m_axis_tdata[OUT_REP_BIT]              = out_rep;
    m_axis_tdata[OUT_ABOVE_LSB +: MASK_W]  = out_above;
    m_axis_tdata[OUT_BELOW_LSB +: MASK_W]  = out_below;
    m_axis_tdata[OUT_SCHED_BIT]            = out_sched;
    m_axis_tdata[OUT_PERS_LSB +: 16]       = out_pers;
  end

endmodule

// ===== rtl/slsm_checker.sv =====
// Port-level checks for the sensor limit safety monitor, bound to the top.
// Depends on slsm_pkg and sensor_limit_safety_monitor_defines.svh.
`timescale 1ns / 1ps
`include "sensor_limit_safety_monitor_defines.svh"

module slsm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic [slsm_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready
);
  import slsm_pkg::*;

  logic out_req;
  logic seen_safe;
  logic safe_b, shut_b, rep_b, sched_b;

  assign out_req = m_axis_tvalid && m_axis_tready;
  assign safe_b  = m_axis_tdata[OUT_SAFE_BIT];
  assign shut_b  = m_axis_tdata[OUT_SHUT_BIT];
  assign rep_b   = m_axis_tdata[OUT_REP_BIT];
  assign sched_b = m_axis_tdata[OUT_SCHED_BIT];

  // safe mode only clears on reset
  always_ff @(posedge clk) begin
    if (rst) seen_safe <= 1'b0;
    else if (out_req && safe_b) seen_safe <= 1'b1;
  end

  `SLSM_ASSERT(a_safe_sticky, out_req && seen_safe |-> safe_b)
  `SLSM_ASSERT(a_flags_imply_safe, m_axis_tvalid && (shut_b || rep_b) |-> safe_b)
  `SLSM_ASSERT(a_sched_implies_safe, m_axis_tvalid && sched_b |-> safe_b)
  `SLSM_ASSERT(a_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

endmodule

bind sensor_limit_safety_monitor slsm_checker u_slsm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ===== verif/sensor_limit_safety_monitor_tb.sv =====
// Self-checking bench for sensor_limit_safety_monitor: streams command requests
// through seven register settings and checks every status result against a local
// model. Depends on slsm_pkg and the RTL top level.
`timescale 1ns / 1ps

module sensor_limit_safety_monitor_tb;
  import slsm_pkg::*;

  typedef struct {
    cmd_t               cmd;
    logic [3:0]         index;
    logic signed [31:0] value;
    logic signed [31:0] low;
    logic signed [31:0] high;
    logic [15:0]        ov;
  } monitor_req_t;

  typedef struct {
    logic        safe;
    logic        shut;
    logic        clr;
    logic        rep;
    logic [15:0] above;
    logic [15:0] below;
    logic        sched;
    logic [15:0] pers;
  } status_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic [IN_W-1:0]      s_axis_tdata;
  logic [1:0]           s_axis_tuser;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_wr_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  sensor_limit_safety_monitor u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register copies seen by the model
  logic        cfg_pbp;
  logic [15:0] cfg_mask;
  logic [7:0]  cfg_tps, cfg_min_beats, cfg_startup, cfg_report_secs;
  logic [4:0]  cfg_count;

  // model state
  logic [7:0]         tick_ctr, report_ctr, beats;
  logic [15:0]        secs;
  logic [15:0]        ov_prev, ov_found, above_seen, below_seen;
  logic               safe_latched, wd_failed;
  logic signed [31:0] reading [SENSORS];
  logic signed [31:0] low_lim [SENSORS];
  logic signed [31:0] high_lim[SENSORS];

  // what the stimulus side believes, used to build well-formed traffic
  logic               gen_pbp;
  logic [15:0]        gen_mask, gen_prev_ov;
  logic signed [31:0] gen_low [SENSORS];
  logic signed [31:0] gen_high[SENSORS];

  monitor_req_t req_queue[$];
  status_t      status_due[$];
  monitor_req_t cur_req;
  status_t      due, got;
  logic         req_taken;
  int           src_idle_pct, sink_stall_pct;
  int           issued_total, accepted_total, results_seen, reports_seen;
  int           phases_run, errors;

  task automatic flag_error(string msg);
    // keep the log bounded if the block is badly broken
    if (errors < 50) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, int unsigned seen, int unsigned want);
    if (seen != want)
      flag_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                           results_seen, name, seen, want));
  endtask

  function automatic status_t predict_status(monitor_req_t it);
    status_t             r;
    logic [7:0]          tps, rps;
    logic [32:0]         sum;
    logic                hit;
    int                  n, i;
    r = '{default: '0};
    case (it.cmd)
      CMD_TICK: begin
        tps = (cfg_tps == 0) ? 8'd1 : cfg_tps;
        rps = (cfg_report_secs == 0) ? 8'd1 : cfg_report_secs;
        if (cfg_pbp && !safe_latched) begin
          r.clr = (it.ov != 0);
          ov_found = it.ov & ov_prev & cfg_mask;
          if (ov_found != 0) safe_latched = 1'b1;
          ov_prev = it.ov;
        end
        tick_ctr = tick_ctr + 8'd1;
        if (tick_ctr >= tps) begin
          tick_ctr = 0;
          if (secs != 16'hFFFF) secs = secs + 16'd1;
          if (secs > cfg_startup) begin
            if (wd_failed || beats < cfg_min_beats) begin
              wd_failed = 1'b1;
              safe_latched = 1'b1;
            end
            beats = 0;
            n = (cfg_count < SENSORS) ? cfg_count : SENSORS;
            hit = 1'b0;
            for (i = 0; i < n; i++) begin
              if (reading[i] > high_lim[i]) begin
                hit = 1'b1;
                above_seen[i] = 1'b1;
              end
              if (reading[i] < low_lim[i]) begin
                hit = 1'b1;
                below_seen[i] = 1'b1;
              end
            end
            if (hit || above_seen != 0 || below_seen != 0) safe_latched = 1'b1;
          end
          report_ctr = report_ctr + 8'd1;
          if (report_ctr >= rps) begin
            report_ctr = 0;
            r.rep = safe_latched;
          end
        end
        r.shut = safe_latched;
      end
      CMD_HEARTBEAT: if (beats != 8'hFF) beats = beats + 8'd1;
      CMD_VALUE:     reading[it.index] = it.value;
      default: begin
        low_lim[it.index]  = it.low;
        high_lim[it.index] = it.high;
        // floor of the mean, sum kept one bit wider so nothing overflows
        sum = {it.low[31], it.low} + {it.high[31], it.high};
        reading[it.index] = sum[32:1];
      end
    endcase
    r.safe  = safe_latched;
    r.above = above_seen;
    r.below = below_seen;
    r.sched = wd_failed;
    r.pers  = ov_found;
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_request(monitor_req_t it);
    logic [IN_W-1:0] bits;
    bits                          = '0;
    bits[IN_IDX_LSB +: 4]         = it.index;
    bits[IN_VAL_LSB +: VALUE_W]   = it.value;
    bits[IN_LOW_LSB +: VALUE_W]   = it.low;
    bits[IN_HIGH_LSB +: VALUE_W]  = it.high;
    bits[IN_OV_LSB +: 16]         = it.ov;
    return bits;
  endfunction

  // request driver: changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || req_taken) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_req = req_queue.pop_front();
          s_axis_tdata  <= pack_request(cur_req);
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: model update on each accepted request, compare on each result
  always @(posedge clk) begin
    if (rst) begin
      req_taken    <= 1'b0;
      tick_ctr     = 0;
      report_ctr   = 0;
      beats        = 0;
      secs         = 0;
      ov_prev      = 0;
      ov_found     = 0;
      above_seen   = 0;
      below_seen   = 0;
      safe_latched = 1'b0;
      wd_failed    = 1'b0;
      foreach (reading[k]) begin
        reading[k]  = 0;
        low_lim[k]  = 0;
        high_lim[k] = 0;
      end
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        status_due.push_back(predict_status(cur_req));
        accepted_total++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_due.size() == 0) begin
          flag_error("status result with no request outstanding");
        end else begin
          due       = status_due.pop_front();
          got.safe  = m_axis_tdata[OUT_SAFE_BIT];
          got.shut  = m_axis_tdata[OUT_SHUT_BIT];
          got.clr   = m_axis_tdata[OUT_CLR_BIT];
          got.rep   = m_axis_tdata[OUT_REP_BIT];
          got.above = m_axis_tdata[OUT_ABOVE_LSB +: MASK_W];
          got.below = m_axis_tdata[OUT_BELOW_LSB +: MASK_W];
          got.sched = m_axis_tdata[OUT_SCHED_BIT];
          got.pers  = m_axis_tdata[OUT_PERS_LSB +: 16];
          check_field("safe_mode", got.safe, due.safe);
          check_field("shut_down_now", got.shut, due.shut);
          check_field("overload_clear", got.clr, due.clr);
          check_field("report_due", got.rep, due.rep);
          check_field("above_tripped", got.above, due.above);
          check_field("below_tripped", got.below, due.below);
          check_field("scheduler_failed", got.sched, due.sched);
          check_field("persistent_overload", got.pers, due.pers);
          if (got.rep) reports_seen++;
          results_seen++;
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'(int'($urandom_range(511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  task automatic post(monitor_req_t it);
    if (it.cmd == CMD_TICK && gen_pbp) gen_prev_ov = it.ov;
    if (it.cmd == CMD_LIMIT) begin
      gen_low[it.index]  = it.low;
      gen_high[it.index] = it.high;
    end
    req_queue.push_back(it);
    issued_total++;
  endtask

  task automatic directed(cmd_t cmd, logic [3:0] idx, logic signed [31:0] value,
                          logic signed [31:0] low, logic signed [31:0] high,
                          logic [15:0] ov);
    monitor_req_t it;
    it = '{cmd, idx, value, low, high, ov};
    post(it);
  endtask

  // well_formed keeps readings inside their limits and overload bits from
  // persisting under the mask, so the block stays out of safe mode
  function automatic monitor_req_t make_request(bit well_formed, bit limit_only);
    monitor_req_t       it;
    logic signed [31:0] a, b;
    longint             span, offset;
    int                 pick;
    it.index = 4'($urandom_range(15));
    it.value = rand_word();
    it.low   = rand_word();
    it.high  = rand_word();
    it.ov    = 16'($urandom_range(16'hFFFF));
    pick     = limit_only ? 99 : $urandom_range(99);
    if (pick < 45)      it.cmd = CMD_TICK;
    else if (pick < 65) it.cmd = CMD_HEARTBEAT;
    else if (pick < 90) it.cmd = CMD_VALUE;
    else                it.cmd = CMD_LIMIT;
    if (well_formed) begin
      if (it.cmd == CMD_TICK && gen_pbp) it.ov = it.ov & ~(gen_prev_ov & gen_mask);
      if (it.cmd == CMD_LIMIT) begin
        a = it.low;
        b = it.high;
        it.low  = (a < b) ? a : b;
        it.high = (a < b) ? b : a;
      end
      if (it.cmd == CMD_VALUE) begin
        a = gen_low[it.index];
        b = gen_high[it.index];
        case ($urandom_range(5))
          0:       it.value = a;
          1:       it.value = b;
          default: begin
            span     = longint'(b) - longint'(a);
            offset   = longint'({$urandom, $urandom} % (span + 1));
            it.value = 32'(longint'(a) + offset);
          end
        endcase
      end
    end
    return it;
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_index <= idx;
    cfg_wr_data  <= data;
    case (idx)
      CFG_POWER_BOARD:   cfg_pbp         = data[0];
      CFG_OVERLOAD_MASK: cfg_mask        = data;
      CFG_TICKS_PER_SEC: cfg_tps         = data[7:0];
      CFG_MIN_HEARTBEAT: cfg_min_beats   = data[7:0];
      CFG_STARTUP_SEC:   cfg_startup     = data[7:0];
      CFG_REPORT_SEC:    cfg_report_secs = data[7:0];
      CFG_SENSOR_COUNT:  cfg_count       = data[4:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic pbp, logic [15:0] mask, logic [7:0] tps,
                           logic [7:0] min_beats, logic [7:0] startup,
                           logic [7:0] report_secs, logic [4:0] count);
    set_reg(CFG_POWER_BOARD, {15'd0, pbp});
    set_reg(CFG_OVERLOAD_MASK, mask);
    set_reg(CFG_TICKS_PER_SEC, {8'd0, tps});
    set_reg(CFG_MIN_HEARTBEAT, {8'd0, min_beats});
    set_reg(CFG_STARTUP_SEC, {8'd0, startup});
    set_reg(CFG_REPORT_SEC, {8'd0, report_secs});
    set_reg(CFG_SENSOR_COUNT, {11'd0, count});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    gen_pbp  = pbp;
    gen_mask = mask;
  endtask

  task automatic wait_idle();
    while (accepted_total != issued_total || status_due.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int src_pct, int sink_pct, bit well_formed, int count);
    monitor_req_t it;
    int           i;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    // well-formed traffic starts by giving every sensor sane limits
    if (well_formed) begin
      for (i = 0; i < SENSORS; i++) begin
        it = make_request(1'b1, 1'b1);
        it.index = 4'(i);
        post(it);
      end
    end
    for (i = 0; i < count; i++) post(make_request(well_formed, 1'b0));
    wait_idle();
    phases_run++;
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tdata   = '0;
    s_axis_tuser   = CMD_TICK;
    s_axis_tvalid  = 1'b0;
    m_axis_tready  = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_index   = CFG_POWER_BOARD;
    cfg_wr_data    = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    issued_total   = 0;
    accepted_total = 0;
    results_seen   = 0;
    reports_seen   = 0;
    phases_run     = 0;
    errors         = 0;
    cfg_pbp         = RST_POWER_BOARD;
    cfg_mask        = RST_OVERLOAD_MASK;
    cfg_tps         = RST_TICKS_PER_SEC;
    cfg_min_beats   = RST_MIN_HEARTBEAT;
    cfg_startup     = RST_STARTUP_SEC;
    cfg_report_secs = RST_REPORT_SEC;
    cfg_count       = RST_SENSOR_COUNT;
    gen_pbp         = RST_POWER_BOARD;
    gen_mask        = RST_OVERLOAD_MASK;
    gen_prev_ov     = '0;
    foreach (gen_low[k]) begin
      gen_low[k]  = 0;
      gen_high[k] = 0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: overload extremes, every command, limit corner cases
    directed(CMD_TICK, 4'd0, rand_word(), rand_word(), rand_word(), 16'h0000);
    directed(CMD_TICK, 4'd9, rand_word(), rand_word(), rand_word(), 16'hFFFF);
    directed(CMD_TICK, 4'd3, rand_word(), rand_word(), rand_word(), 16'hFFFF);
    directed(CMD_TICK, 4'd5, rand_word(), rand_word(), rand_word(), 16'h5555);
    directed(CMD_TICK, 4'd6, rand_word(), rand_word(), rand_word(), 16'hAAAA);
    directed(CMD_HEARTBEAT, 4'd0, 0, 0, 0, 16'h0000);
    directed(CMD_HEARTBEAT, 4'd15, -1, -1, -1, 16'hFFFF);
    directed(CMD_VALUE, 4'd0, 32'sh7FFF_FFFF, 0, 0, 16'h0000);
    directed(CMD_VALUE, 4'd15, 32'sh8000_0000, 0, 0, 16'h0000);
    // midpoint of the full range rounds down to -1
    directed(CMD_LIMIT, 4'd1, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'h0000);
    directed(CMD_LIMIT, 4'd2, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0000);
    directed(CMD_LIMIT, 4'd3, 0, 32'sh8000_0000, 32'sh8000_0000, 16'h0000);
    directed(CMD_LIMIT, 4'd4, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'h0000);
    directed(CMD_LIMIT, 4'd5, 0, -3, 0, 16'h0000);
    directed(CMD_LIMIT, 4'd6, 0, 100, 200, 16'h0000);
    directed(CMD_VALUE, 4'd6, 100, 0, 0, 16'h0000);
    directed(CMD_VALUE, 4'd6, 200, 0, 0, 16'h0000);
    directed(CMD_VALUE, 4'd7, 0, 0, 0, 16'h0000);
    directed(CMD_TICK, 4'd10, rand_word(), rand_word(), rand_word(), 16'h0001);
    directed(CMD_TICK, 4'd12, rand_word(), rand_word(), rand_word(), 16'h0000);
    wait_idle();
    phases_run++;

    // zero periods act as one, checks every tick, oversized sensor count
    configure(1'b1, 16'($urandom_range(16'hFFFF)), 8'd0, 8'd0, 8'd0, 8'd0, 5'd31);
    run_phase(0, 0, 1'b1, 300);
    // power board absent: overload sampling skipped
    configure(1'b0, 16'hFFFF, 8'd7, 8'd0, 8'd2, 8'd2, 5'd16);
    run_phase(72, 0, 1'b1, 300);
    // shorter second while the tick phase may already be past it
    configure(1'b1, 16'($urandom_range(16'hFFFF)), 8'd2, 8'd0, 8'd0, 8'd1, 5'd16);
    run_phase(0, 72, 1'b1, 300);
    // unconstrained traffic: overloads, trips and watchdog failure latch
    configure(1'b1, 16'hFFFF, 8'd4, 8'd255, 8'd0, 8'd3, 5'd16);
    run_phase(38, 38, 1'b0, 300);
    configure(1'b1, 16'h0000, 8'd255, 8'd4, 8'd255, 8'd255, 5'd5);
    run_phase(0, 0, 1'b0, 150);
    configure(1'b0, 16'h8001, 8'd1, 8'd0, 8'd0, 8'd1, 5'd0);
    run_phase(38, 38, 1'b0, 200);

    // let any stray result show up before the verdict
    repeat (SENSORS + 8) @(negedge clk);
    $display("Checked %0d status results over %0d register settings (%0d report requests).",
             results_seen, phases_run, reports_seen);
    $display("Final state: safe mode %0d, scheduler failure %0d, above 0x%04h, below 0x%04h.",
             safe_latched, wd_failed, above_seen, below_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still outstanding", status_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule
